>>> sv/civag_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the convolution indirection address generator.
// Depends on nothing; civag_ifs, civag_cfg and the core use it by scoped names.
package civag_pkg;

    // Default tile height of the indirection table (pixels per group).
    localparam int M_STEP_DEFAULT = 32;

    // Largest legal register values; anything beyond is an illegal configuration.
    localparam int MAX_SIDE     = 1024;
    localparam int MAX_CHANNELS = 4096;
    localparam int MAX_KERNEL   = 64;

    // Configuration port.
    localparam int REG_COUNT = 8;
    localparam int IDX_W     = 3;
    localparam int DATA_W    = 13;

    // Register field widths.
    localparam int SIDE_W   = 11;
    localparam int CHAN_W   = 13;
    localparam int KERN_W   = 7;
    localparam int STRIDE_W = 7;
    localparam int PAD_W    = 6;

    // Internal widths that the register widths settle. A padded side is at most
    // 2047 + 2 * 63, which needs 12 bits; a kernel area is at most 127 * 127.
    localparam int ROW_W    = 12;
    localparam int TAP_W    = 7;
    localparam int TIDX_W   = 14;
    localparam int LIN_W    = 22;
    localparam int SLOT_W   = 33;
    localparam int OFFSET_W = 32;
    localparam int CMP_W    = 17;

    localparam int PIXEL_MAX       = 2173 * 2173;
    localparam int KERNEL_AREA_MAX = 127 * 127;

    localparam logic [CMP_W-1:0] MAX_SIDE_L     = CMP_W'(MAX_SIDE);
    localparam logic [CMP_W-1:0] MAX_CHANNELS_L = CMP_W'(MAX_CHANNELS);
    localparam logic [CMP_W-1:0] MAX_KERNEL_L   = CMP_W'(MAX_KERNEL);

    typedef enum logic [IDX_W-1:0] {
        REG_INPUT_HEIGHT   = 3'd0,
        REG_INPUT_WIDTH    = 3'd1,
        REG_INPUT_CHANNELS = 3'd2,
        REG_KERNEL_HEIGHT  = 3'd3,
        REG_KERNEL_WIDTH   = 3'd4,
        REG_STRIDE_HEIGHT  = 3'd5,
        REG_STRIDE_WIDTH   = 3'd6,
        REG_PAD_AMOUNT     = 3'd7
    } cfg_reg_t;

    // Configuration as seen by the walk and the address pipeline.
    typedef struct packed {
        logic [SIDE_W-1:0]   in_h;
        logic [SIDE_W-1:0]   in_w;
        logic [CHAN_W-1:0]   chans;
        logic [KERN_W-1:0]   kern_h;
        logic [KERN_W-1:0]   kern_w;
        logic [STRIDE_W-1:0] stride_h;
        logic [STRIDE_W-1:0] stride_w;
        logic [PAD_W-1:0]    pad;
        logic [ROW_W-1:0]    out_h;
        logic [ROW_W-1:0]    out_w;
        logic                ok;
        logic                busy;
    } cfg_t;

endpackage

>>> sv/civag_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the indirection address generator:
// request words, result words and configuration writes. Uses civag_pkg.
interface civag_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface civag_out_if;
    logic                          valid;
    logic                          ready;
    logic                          valid_res;
    logic [civag_pkg::SLOT_W-1:0]   slot_index;
    logic                          is_pad;
    logic [civag_pkg::OFFSET_W-1:0] input_offset;
    logic                          last;

    modport source (output valid, output valid_res, output slot_index, output is_pad,
                    output input_offset, output last, input ready);
    modport sink (input valid, input valid_res, input slot_index, input is_pad,
                  input input_offset, input last, output ready);
endinterface

interface civag_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [civag_pkg::IDX_W-1:0]  index;
    logic [civag_pkg::DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/civag_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module civag_div #(
    parameter int N = 12,
    parameter int D = 7
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         busy,
    output logic         done,
    output logic [N-1:0] quotient
);

    localparam int CNT_W = $clog2(N + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;
    logic [D-1:0]     rem_reg;
    logic [D-1:0]     rem_next;
    logic [N-1:0]     quo_reg;
    logic [N-1:0]     quo_next;
    logic [D:0]       shifted;
    logic [D:0]       diff;
    logic             fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[N-1]};
        diff      = shifted - {1'b0, divisor};
        fits      = shifted >= {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = CNT_W'(N);
        end
        else if (cnt_reg != '0)
        begin
            // The remainder stays below the divisor, so D bits hold it.
            rem_next  = fits ? diff[D-1:0] : shifted[D-1:0];
            quo_next  = {quo_reg[N-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = (cnt_reg != '0);
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> sv/civag_cfg.sv
`timescale 1ns / 1ps
// Configuration registers and the values derived from them: output extents,
// kernel tile size and the legality check. Uses civag_pkg, civag_ifs, civag_div.
module civag_cfg #(
    parameter int M_STEP = civag_pkg::M_STEP_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    civag_cfg_if.sink       cfg,
    output civag_pkg::cfg_t state,
    output logic [$clog2(civag_pkg::KERNEL_AREA_MAX * M_STEP + 1)-1:0] kkm
);

    localparam int ROW_W  = civag_pkg::ROW_W;
    localparam int KERN_W = civag_pkg::KERN_W;
    localparam int CMP_W  = civag_pkg::CMP_W;
    localparam int TIDX_W = civag_pkg::TIDX_W;
    localparam int KKM_W  = $clog2(civag_pkg::KERNEL_AREA_MAX * M_STEP + 1);

    logic [civag_pkg::SIDE_W-1:0]   in_h_reg;
    logic [civag_pkg::SIDE_W-1:0]   in_w_reg;
    logic [civag_pkg::CHAN_W-1:0]   chans_reg;
    logic [KERN_W-1:0]              kern_h_reg;
    logic [KERN_W-1:0]              kern_w_reg;
    logic [civag_pkg::STRIDE_W-1:0] stride_h_reg;
    logic [civag_pkg::STRIDE_W-1:0] stride_w_reg;
    logic [civag_pkg::PAD_W-1:0]    pad_reg;

    logic              pending_reg;
    logic              ge_h_reg;
    logic              ge_w_reg;
    logic [TIDX_W-1:0] kk_reg;
    logic [KKM_W-1:0]  kkm_reg;
    logic [ROW_W-1:0]  out_h_reg;
    logic [ROW_W-1:0]  out_w_reg;
    logic              ok_reg;

    logic              write;
    logic [ROW_W-1:0]  padded_h;
    logic [ROW_W-1:0]  padded_w;
    logic              ge_h;
    logic              ge_w;
    logic [ROW_W-1:0]  span_h;
    logic [ROW_W-1:0]  span_w;
    logic [TIDX_W-1:0] kk_prod;
    logic [KKM_W-1:0]  kkm_prod;
    logic              legal;
    logic              div_h_busy;
    logic              div_w_busy;
    logic              div_h_done;
    logic              div_w_done;
    logic [ROW_W-1:0]  quo_h;
    logic [ROW_W-1:0]  quo_w;

    assign cfg.ready = 1'b1;
    assign write     = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_h_reg     <= civag_pkg::SIDE_W'(1);
            in_w_reg     <= civag_pkg::SIDE_W'(1);
            chans_reg    <= civag_pkg::CHAN_W'(1);
            kern_h_reg   <= KERN_W'(1);
            kern_w_reg   <= KERN_W'(1);
            stride_h_reg <= civag_pkg::STRIDE_W'(1);
            stride_w_reg <= civag_pkg::STRIDE_W'(1);
            pad_reg      <= '0;
        end
        else if (write)
        begin
            unique case (civag_pkg::cfg_reg_t'(cfg.index))
                civag_pkg::REG_INPUT_HEIGHT:   in_h_reg     <= cfg.data[civag_pkg::SIDE_W-1:0];
                civag_pkg::REG_INPUT_WIDTH:    in_w_reg     <= cfg.data[civag_pkg::SIDE_W-1:0];
                civag_pkg::REG_INPUT_CHANNELS: chans_reg    <= cfg.data[civag_pkg::CHAN_W-1:0];
                civag_pkg::REG_KERNEL_HEIGHT:  kern_h_reg   <= cfg.data[KERN_W-1:0];
                civag_pkg::REG_KERNEL_WIDTH:   kern_w_reg   <= cfg.data[KERN_W-1:0];
                civag_pkg::REG_STRIDE_HEIGHT:
                    stride_h_reg <= cfg.data[civag_pkg::STRIDE_W-1:0];
                civag_pkg::REG_STRIDE_WIDTH:
                    stride_w_reg <= cfg.data[civag_pkg::STRIDE_W-1:0];
                civag_pkg::REG_PAD_AMOUNT:     pad_reg      <= cfg.data[civag_pkg::PAD_W-1:0];
            endcase
        end
    end

    // Padded extents and the distance the kernel can slide along each axis.
    always_comb
    begin
        padded_h = ROW_W'(in_h_reg) + ROW_W'({pad_reg, 1'b0});
        padded_w = ROW_W'(in_w_reg) + ROW_W'({pad_reg, 1'b0});
        ge_h     = padded_h >= ROW_W'(kern_h_reg);
        ge_w     = padded_w >= ROW_W'(kern_w_reg);
        span_h   = ge_h ? padded_h - ROW_W'(kern_h_reg) : '0;
        span_w   = ge_w ? padded_w - ROW_W'(kern_w_reg) : '0;
        kk_prod  = TIDX_W'(kern_h_reg) * TIDX_W'(kern_w_reg);
        kkm_prod = KKM_W'(kk_reg) * KKM_W'(M_STEP);
        legal    = (stride_h_reg != '0) && (stride_w_reg != '0) &&
                   (kern_h_reg != '0) && (kern_w_reg != '0) &&
                   (CMP_W'(kern_h_reg) <= civag_pkg::MAX_KERNEL_L) &&
                   (CMP_W'(kern_w_reg) <= civag_pkg::MAX_KERNEL_L) &&
                   (CMP_W'(in_h_reg) <= civag_pkg::MAX_SIDE_L) &&
                   (CMP_W'(in_w_reg) <= civag_pkg::MAX_SIDE_L) &&
                   (chans_reg != '0) &&
                   (CMP_W'(chans_reg) <= civag_pkg::MAX_CHANNELS_L);
    end

    civag_div #(
        .N (ROW_W),
        .D (civag_pkg::STRIDE_W)
    ) u_div_h (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pending_reg),
        .dividend (span_h),
        .divisor  (stride_h_reg),
        .busy     (div_h_busy),
        .done     (div_h_done),
        .quotient (quo_h)
    );

    civag_div #(
        .N (ROW_W),
        .D (civag_pkg::STRIDE_W)
    ) u_div_w (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pending_reg),
        .dividend (span_w),
        .divisor  (stride_w_reg),
        .busy     (div_w_busy),
        .done     (div_w_done),
        .quotient (quo_w)
    );

    // Derived values reset to what the reset register values give.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            ge_h_reg    <= 1'b1;
            ge_w_reg    <= 1'b1;
            kk_reg      <= TIDX_W'(1);
            kkm_reg     <= KKM_W'(M_STEP);
            out_h_reg   <= ROW_W'(1);
            out_w_reg   <= ROW_W'(1);
            ok_reg      <= 1'b1;
        end
        else
        begin
            pending_reg <= write;
            if (pending_reg)
            begin
                ge_h_reg <= ge_h;
                ge_w_reg <= ge_w;
                kk_reg   <= kk_prod;
            end
            if (div_h_done && div_w_done)
            begin
                kkm_reg   <= kkm_prod;
                out_h_reg <= ge_h_reg ? quo_h + ROW_W'(1) : '0;
                out_w_reg <= ge_w_reg ? quo_w + ROW_W'(1) : '0;
                ok_reg    <= legal && ge_h_reg && ge_w_reg;
            end
        end
    end

    always_comb
    begin
        state.in_h     = in_h_reg;
        state.in_w     = in_w_reg;
        state.chans    = chans_reg;
        state.kern_h   = kern_h_reg;
        state.kern_w   = kern_w_reg;
        state.stride_h = stride_h_reg;
        state.stride_w = stride_w_reg;
        state.pad      = pad_reg;
        state.out_h    = out_h_reg;
        state.out_w    = out_w_reg;
        state.ok       = ok_reg;
        state.busy     = pending_reg || div_h_busy || div_w_busy || div_h_done || div_w_done;
    end

    assign kkm = kkm_reg;

endmodule

>>> sv/conv_indirection_address_generator_core.sv
`timescale 1ns / 1ps
// Top level of the convolution indirection address generator.
// Uses civag_pkg, the channel interfaces in civag_ifs, civag_cfg and civag_div.
//
// Every request word advances a walk over the indirection table of a padded,
// strided 2D convolution on an NHWC image, in output-pixel then kernel-tap
// order, and yields one result word: its slot in the table (tiled in groups
// of M_STEP pixels), a pad mark or the element offset of the input pixel, and
// a last mark on the final entry, after which the walk wraps. A request with
// restart set starts the walk over first. A configuration that gives no output
// pixels, or holds an illegal value, yields one result word with valid_res low
// and all other fields zero, and the walk holds. The block takes one request
// word per clock and delivers one result word per clock while res.ready is
// high and no configuration update is in progress; a word passes stages 1, 2
// and 3 and the result register. The walk counters step incrementally; row and
// column are multiplied in stage 2, the linear pixel index in stage 3 and the
// channel stride in the result stage. Stages hold words independently, so a
// waiting result does not block acceptance until the pipeline is full. After
// any configuration write the request side is not ready while two restoring
// dividers, one quotient bit per cycle over 12 bits, find the output extents.
module conv_indirection_address_generator_core #(
    parameter int M_STEP = civag_pkg::M_STEP_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    civag_in_if.sink     req,
    civag_out_if.source  res,
    civag_cfg_if.sink    cfg
);

    localparam int ROW_W    = civag_pkg::ROW_W;
    localparam int TAP_W    = civag_pkg::TAP_W;
    localparam int TIDX_W   = civag_pkg::TIDX_W;
    localparam int LIN_W    = civag_pkg::LIN_W;
    localparam int SLOT_W   = civag_pkg::SLOT_W;
    localparam int OFFSET_W = civag_pkg::OFFSET_W;
    localparam int SIDE_W   = civag_pkg::SIDE_W;
    localparam int CHAN_W   = civag_pkg::CHAN_W;
    localparam int STRIDE_W = civag_pkg::STRIDE_W;
    localparam int LANE_W   = (M_STEP > 1) ? $clog2(M_STEP) : 1;
    localparam int GRP_W    = $clog2(civag_pkg::PIXEL_MAX / M_STEP + 1);
    localparam int KKM_W    = $clog2(civag_pkg::KERNEL_AREA_MAX * M_STEP + 1);
    localparam int HI_W     = GRP_W + KKM_W;
    localparam int SUM_W    = (HI_W > SLOT_W) ? HI_W : SLOT_W;
    localparam int HP_W     = ROW_W + STRIDE_W;
    localparam int LP_W     = ROW_W + SIDE_W;
    localparam int OP_W     = LIN_W + CHAN_W;

    localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(M_STEP - 1);

    civag_pkg::cfg_t   cs;
    logic [KKM_W-1:0]  kkm;

    // Walk state. The pixel number is kept as a tile group and a lane in it.
    logic [ROW_W-1:0]  out_row_reg;
    logic [ROW_W-1:0]  out_col_reg;
    logic [TAP_W-1:0]  tap_row_reg;
    logic [TAP_W-1:0]  tap_col_reg;
    logic [TIDX_W-1:0] tap_idx_reg;
    logic [LANE_W-1:0] lane_reg;
    logic [GRP_W-1:0]  group_reg;

    logic [ROW_W-1:0]  out_row_next;
    logic [ROW_W-1:0]  out_col_next;
    logic [TAP_W-1:0]  tap_row_next;
    logic [TAP_W-1:0]  tap_col_next;
    logic [TIDX_W-1:0] tap_idx_next;
    logic [LANE_W-1:0] lane_next;
    logic [GRP_W-1:0]  group_next;

    logic [ROW_W-1:0]  cur_row;
    logic [ROW_W-1:0]  cur_col;
    logic [TAP_W-1:0]  cur_trow;
    logic [TAP_W-1:0]  cur_tcol;
    logic [TIDX_W-1:0] cur_tidx;
    logic [LANE_W-1:0] cur_lane;
    logic [GRP_W-1:0]  cur_group;
    logic              out_of_range;
    logic              wipe;
    logic              is_last;
    logic              col_wrap;
    logic              row_wrap;
    logic              pix_step;
    logic              lane_wrap;
    logic              ocol_wrap;
    logic              req_fire;

    // Stage 1: the walk position of the word.
    logic              s1_v_reg;
    logic              s1_vres_reg;
    logic              s1_last_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [ROW_W-1:0]  s1_col_reg;
    logic [TAP_W-1:0]  s1_trow_reg;
    logic [TAP_W-1:0]  s1_tcol_reg;
    logic [TIDX_W-1:0] s1_tidx_reg;
    logic [LANE_W-1:0] s1_lane_reg;
    logic [GRP_W-1:0]  s1_group_reg;

    // Stage 2: padded image coordinates and the two slot terms.
    logic              s2_v_reg;
    logic              s2_vres_reg;
    logic              s2_last_reg;
    logic [ROW_W-1:0]  s2_h_reg;
    logic [ROW_W-1:0]  s2_w_reg;
    logic [HI_W-1:0]   s2_hi_reg;
    logic [KKM_W-1:0]  s2_lo_reg;
    logic [ROW_W-1:0]  s2_h_next;
    logic [ROW_W-1:0]  s2_w_next;
    logic [HI_W-1:0]   s2_hi_next;
    logic [KKM_W-1:0]  s2_lo_next;
    logic [HP_W-1:0]   h_prod;
    logic [HP_W-1:0]   w_prod;

    // Stage 3: pad mark, linear pixel index and slot.
    logic              s3_v_reg;
    logic              s3_vres_reg;
    logic              s3_last_reg;
    logic              s3_pad_reg;
    logic [LIN_W-1:0]  s3_lin_reg;
    logic [SLOT_W-1:0] s3_slot_reg;
    logic              s3_pad_next;
    logic [LIN_W-1:0]  s3_lin_next;
    logic [SLOT_W-1:0] s3_slot_next;
    logic [ROW_W-1:0]  h_rel;
    logic [ROW_W-1:0]  w_rel;
    logic [LP_W-1:0]   lin_prod;
    logic [SUM_W-1:0]  slot_sum;

    // Result register.
    logic                out_v_reg;
    logic                out_vres_reg;
    logic                out_last_reg;
    logic                out_pad_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [OP_W-1:0]     offset_prod;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic out_ready;

    civag_cfg #(
        .M_STEP (M_STEP)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .state (cs),
        .kkm   (kkm)
    );

    // Each stage takes a new word when it is empty or its word moves on.
    assign out_ready = !out_v_reg || res.ready;
    assign s3_ready  = !s3_v_reg || out_ready;
    assign s2_ready  = !s2_v_reg || s3_ready;
    assign s1_ready  = !s1_v_reg || s2_ready;
    assign req.ready = s1_ready && !cs.busy;
    assign req_fire  = req.valid && req.ready;

    // Walk update. A position left out of range by a configuration change
    // starts the walk over when the new configuration is ok, as a restart does.
    always_comb
    begin
        out_of_range = (out_row_reg >= cs.out_h) || (out_col_reg >= cs.out_w) ||
                       (tap_row_reg >= cs.kern_h) || (tap_col_reg >= cs.kern_w);
        wipe      = req.restart || (cs.ok && out_of_range);
        cur_row   = wipe ? '0 : out_row_reg;
        cur_col   = wipe ? '0 : out_col_reg;
        cur_trow  = wipe ? '0 : tap_row_reg;
        cur_tcol  = wipe ? '0 : tap_col_reg;
        cur_tidx  = wipe ? '0 : tap_idx_reg;
        cur_lane  = wipe ? '0 : lane_reg;
        cur_group = wipe ? '0 : group_reg;

        col_wrap  = (cur_tcol + TAP_W'(1)) == cs.kern_w;
        row_wrap  = (cur_trow + TAP_W'(1)) == cs.kern_h;
        pix_step  = col_wrap && row_wrap;
        lane_wrap = cur_lane == LANE_LAST;
        ocol_wrap = (cur_col + ROW_W'(1)) == cs.out_w;
        is_last   = cs.ok && (cur_row == cs.out_h - ROW_W'(1)) && ocol_wrap && pix_step;

        out_row_next = cur_row;
        out_col_next = cur_col;
        tap_row_next = cur_trow;
        tap_col_next = cur_tcol;
        tap_idx_next = cur_tidx;
        lane_next    = cur_lane;
        group_next   = cur_group;
        if (cs.ok)
        begin
            if (is_last)
            begin
                out_row_next = '0;
                out_col_next = '0;
                tap_row_next = '0;
                tap_col_next = '0;
                tap_idx_next = '0;
                lane_next    = '0;
                group_next   = '0;
            end
            else
            begin
                tap_col_next = col_wrap ? '0 : cur_tcol + TAP_W'(1);
                tap_idx_next = pix_step ? '0 : cur_tidx + TIDX_W'(1);
                if (col_wrap)
                begin
                    tap_row_next = row_wrap ? '0 : cur_trow + TAP_W'(1);
                end
                if (pix_step)
                begin
                    lane_next    = lane_wrap ? '0 : cur_lane + LANE_W'(1);
                    group_next   = lane_wrap ? cur_group + GRP_W'(1) : cur_group;
                    out_col_next = ocol_wrap ? '0 : cur_col + ROW_W'(1);
                    out_row_next = ocol_wrap ? cur_row + ROW_W'(1) : cur_row;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_row_reg <= '0;
            out_col_reg <= '0;
            tap_row_reg <= '0;
            tap_col_reg <= '0;
            tap_idx_reg <= '0;
            lane_reg    <= '0;
            group_reg   <= '0;
        end
        else if (req_fire)
        begin
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            tap_row_reg <= tap_row_next;
            tap_col_reg <= tap_col_next;
            tap_idx_reg <= tap_idx_next;
            lane_reg    <= lane_next;
            group_reg   <= group_next;
        end
    end

    // Stage 2 logic: one multiplier per coordinate and per slot term.
    always_comb
    begin
        h_prod     = HP_W'(s1_row_reg) * HP_W'(cs.stride_h);
        w_prod     = HP_W'(s1_col_reg) * HP_W'(cs.stride_w);
        s2_h_next  = h_prod[ROW_W-1:0] + ROW_W'(s1_trow_reg);
        s2_w_next  = w_prod[ROW_W-1:0] + ROW_W'(s1_tcol_reg);
        s2_hi_next = HI_W'(s1_group_reg) * HI_W'(kkm);
        s2_lo_next = KKM_W'(s1_tidx_reg) * KKM_W'(M_STEP) + KKM_W'(s1_lane_reg);
    end

    // Stage 3 logic: pad test and the row-major pixel index inside the image.
    always_comb
    begin
        h_rel        = s2_h_reg - ROW_W'(cs.pad);
        w_rel        = s2_w_reg - ROW_W'(cs.pad);
        s3_pad_next  = (s2_h_reg < ROW_W'(cs.pad)) || (s2_w_reg < ROW_W'(cs.pad)) ||
                       (h_rel >= ROW_W'(cs.in_h)) || (w_rel >= ROW_W'(cs.in_w));
        lin_prod     = LP_W'(h_rel) * LP_W'(cs.in_w) + LP_W'(w_rel);
        slot_sum     = SUM_W'(s2_hi_reg) + SUM_W'(s2_lo_reg);
        s3_lin_next  = (s3_pad_next || !s2_vres_reg) ? '0 : lin_prod[LIN_W-1:0];
        s3_slot_next = s2_vres_reg ? slot_sum[SLOT_W-1:0] : '0;
    end

    // Result stage: the channel count is the element stride between pixels.
    assign offset_prod = OP_W'(s3_lin_reg) * OP_W'(cs.chans);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_v_reg <= req_fire;
            end
            if (s2_ready)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_ready)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (out_ready)
            begin
                out_v_reg <= s3_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_vres_reg  <= cs.ok;
            s1_last_reg  <= is_last;
            s1_row_reg   <= cur_row;
            s1_col_reg   <= cur_col;
            s1_trow_reg  <= cur_trow;
            s1_tcol_reg  <= cur_tcol;
            s1_tidx_reg  <= cur_tidx;
            s1_lane_reg  <= cur_lane;
            s1_group_reg <= cur_group;
        end
        if (s2_ready && s1_v_reg)
        begin
            s2_vres_reg <= s1_vres_reg;
            s2_last_reg <= s1_last_reg;
            s2_h_reg    <= s2_h_next;
            s2_w_reg    <= s2_w_next;
            s2_hi_reg   <= s2_hi_next;
            s2_lo_reg   <= s2_lo_next;
        end
        if (s3_ready && s2_v_reg)
        begin
            s3_vres_reg <= s2_vres_reg;
            s3_last_reg <= s2_last_reg;
            s3_pad_reg  <= s3_pad_next && s2_vres_reg;
            s3_lin_reg  <= s3_lin_next;
            s3_slot_reg <= s3_slot_next;
        end
        if (out_ready && s3_v_reg)
        begin
            out_vres_reg   <= s3_vres_reg;
            out_last_reg   <= s3_last_reg;
            out_pad_reg    <= s3_pad_reg;
            out_slot_reg   <= s3_slot_reg;
            out_offset_reg <= offset_prod[OFFSET_W-1:0];
        end
    end

    assign res.valid        = out_v_reg;
    assign res.valid_res    = out_vres_reg;
    assign res.slot_index   = out_slot_reg;
    assign res.is_pad       = out_pad_reg;
    assign res.input_offset = out_offset_reg;
    assign res.last         = out_last_reg;

    // A configuration write holds off requests until the extents are recomputed.
    a_cfg_holds_requests: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready) |=> !req.ready)
        else $error("request accepted right after a configuration write");

    // A word from a configuration without output carries nothing but zeros.
    a_invalid_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.valid_res) |->
        (res.slot_index == '0 && !res.is_pad && res.input_offset == '0 && !res.last))
        else $error("invalid result word has nonzero fields");

    // A tap in the padding never points into the image.
    a_pad_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.is_pad) |-> res.input_offset == '0)
        else $error("pad entry has a nonzero input offset");

    // The final entry sends the walk back to its start.
    a_last_wraps_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && is_last) |=>
        (out_row_reg == '0 && out_col_reg == '0 && tap_row_reg == '0 &&
         tap_col_reg == '0 && lane_reg == '0 && group_reg == '0))
        else $error("walk did not wrap after the last entry");

endmodule
